// ----- design/irow_pkg.sv -----
// ----------------------------------------------------------------------------
// irow_pkg
// Shared types and constants for the I420 rectangle outline writer: opcodes,
// strip codes, register indexes, configuration and plane layout bundles.
// ----------------------------------------------------------------------------
package irow_pkg;

    // frame limits and address width
    localparam int MAX_DIM       = 4096;
    localparam int ADDR_BITS     = 24;
    localparam int END_BITS      = 32;
    // cycles from a register write until the layout check is valid again
    localparam int LAYOUT_SETTLE = 7;
    localparam int SETTLE_BITS   = $clog2(LAYOUT_SETTLE + 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STRIP_TOP    = 2'd0,
        STRIP_BOTTOM = 2'd1,
        STRIP_LEFT   = 2'd2,
        STRIP_RIGHT  = 2'd3
    } t_strip;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_LUMA_STRIDE   = 3'd2,
        REG_CHROMA_STRIDE = 3'd3,
        REG_LUMA_OFFSET   = 3'd4,
        REG_U_OFFSET      = 3'd5,
        REG_V_OFFSET      = 3'd6,
        REG_BUFFER_BYTES  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [13:0] luma_stride;
        logic [12:0] chroma_stride;
        logic [23:0] luma_offset;
        logic [23:0] u_offset;
        logic [23:0] v_offset;
        logic [24:0] buffer_bytes;
    } t_cfg;

    // derived plane layout seen by the pixel path
    typedef struct packed {
        logic                 settled;
        logic                 ok;
        logic [ADDR_BITS-1:0] u_base;
        logic [ADDR_BITS-1:0] v_base;
        logic [13:0]          luma_stride;
        logic [12:0]          chroma_stride;
    } t_layout;

endpackage

// ----- design/irow_layout.sv -----
// ----------------------------------------------------------------------------
// irow_layout
// Plane layout pipeline: resolves default strides and plane offsets, works
// out where each plane ends, checks frame dimensions and strides, and checks the plane ends against the buffer size.
// ----------------------------------------------------------------------------
module irow_layout import irow_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_write,
    input  t_cfg    i_cfg,
    output t_layout o_layout
);

    logic [13:0] w_ys;
    logic [12:0] w_cw;
    logic [12:0] w_ch;
    logic [12:0] w_cs;
    logic        w_dim_ok;
    logic        w_stride_ok;
    logic [12:0] w_fh_m1;
    logic [12:0] w_ch_m1;

    logic [13:0] r_ys;
    logic [12:0] r_cw;
    logic [12:0] r_ch;
    logic [12:0] r_cs;
    logic        r_dim_ok;
    logic        r_stride_ok;

    logic [26:0] r_ys_rows;
    logic [26:0] r_ys_last;
    logic [25:0] r_cs_rows;
    logic [25:0] r_cs_last;

    logic [END_BITS-1:0] r_u_base;
    logic [END_BITS-1:0] r_y_end;
    logic [END_BITS-1:0] r_v_base;
    logic [END_BITS-1:0] r_u_end;
    logic [END_BITS-1:0] r_v_end;
    logic                r_ends_ok;
    logic                r_ok;

    logic [SETTLE_BITS-1:0] r_settle;
    logic [SETTLE_BITS-1:0] n_settle;

    // default strides and chroma plane size
    always_comb begin
        w_ys = (i_cfg.luma_stride != 14'd0) ? i_cfg.luma_stride : {1'b0, i_cfg.frame_width};
        w_cw = 13'(({1'b0, i_cfg.frame_width} + 14'd1) >> 1);
        w_ch = 13'(({1'b0, i_cfg.frame_height} + 14'd1) >> 1);
        w_cs = (i_cfg.chroma_stride != 13'd0) ? i_cfg.chroma_stride : w_cw;
        w_dim_ok = (i_cfg.frame_width != 13'd0) && (i_cfg.frame_height != 13'd0)
            && (i_cfg.frame_width <= 13'(MAX_DIM)) && (i_cfg.frame_height <= 13'(MAX_DIM));
        w_stride_ok = (w_ys >= {1'b0, i_cfg.frame_width}) && (w_cs >= w_cw);
        w_fh_m1 = i_cfg.frame_height - 13'd1;
        w_ch_m1 = r_ch - 13'd1;
    end

    // stage one: strides and chroma size
    always_ff @(posedge i_clk) begin
        r_ys        <= w_ys;
        r_cw        <= w_cw;
        r_ch        <= w_ch;
        r_cs        <= w_cs;
        r_dim_ok    <= w_dim_ok;
        r_stride_ok <= w_stride_ok;
    end

    // stage two: plane sizes
    always_ff @(posedge i_clk) begin
        r_ys_rows <= r_ys * i_cfg.frame_height;
        r_ys_last <= r_ys * w_fh_m1;
        r_cs_rows <= r_cs * r_ch;
        r_cs_last <= r_cs * w_ch_m1;
    end

    // stage three: u base and luma end
    always_ff @(posedge i_clk) begin
        r_u_base <= (i_cfg.u_offset != 24'd0) ? END_BITS'(i_cfg.u_offset)
                  : END_BITS'(i_cfg.luma_offset) + END_BITS'(r_ys_rows);
        r_y_end  <= END_BITS'(i_cfg.luma_offset) + END_BITS'(r_ys_last)
                  + END_BITS'(i_cfg.frame_width);
    end

    // stage four: v base and u end
    always_ff @(posedge i_clk) begin
        r_v_base <= (i_cfg.v_offset != 24'd0) ? END_BITS'(i_cfg.v_offset)
                  : r_u_base + END_BITS'(r_cs_rows);
        r_u_end  <= r_u_base + END_BITS'(r_cs_last) + END_BITS'(r_cw);
    end

    // stage five and six: v end and buffer check
    always_ff @(posedge i_clk) begin
        r_v_end   <= r_v_base + END_BITS'(r_cs_last) + END_BITS'(r_cw);
        r_ends_ok <= (r_y_end <= END_BITS'(i_cfg.buffer_bytes))
                  && (r_u_end <= END_BITS'(i_cfg.buffer_bytes));
        r_ok      <= r_dim_ok && r_stride_ok && r_ends_ok
                  && (r_v_end <= END_BITS'(i_cfg.buffer_bytes));
    end

    // settle count after reset or a register write
    always_comb begin
        n_settle = r_settle;
        if (i_cfg_write) begin
            n_settle = SETTLE_BITS'(LAYOUT_SETTLE);
        end else if (r_settle != '0) begin
            n_settle = r_settle - SETTLE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_BITS'(LAYOUT_SETTLE);
        end else begin
            r_settle <= n_settle;
        end
    end

    assign o_layout.settled       = (r_settle == '0);
    assign o_layout.ok            = r_ok;
    assign o_layout.u_base        = r_u_base[ADDR_BITS-1:0];
    assign o_layout.v_base        = r_v_base[ADDR_BITS-1:0];
    assign o_layout.luma_stride   = r_ys;
    assign o_layout.chroma_stride = r_cs;

endmodule

// ----- design/i420_rect_outline_writer_core.sv -----
// ----------------------------------------------------------------------------
// i420_rect_outline_writer_core
// Draws a rectangle outline into an I420 frame buffer, one pixel write per
// tick request, walking top, bottom, left and right border strips.
// ----------------------------------------------------------------------------
// A start request latches a rectangle and produces no write; each tick
// request while a rectangle is active produces one pixel write, and the
// block takes one request per cycle unless the output stalls. Each write
// passes two register stages: the first holds the pixel position and its
// in-frame check, the second the plane addresses from the row-times-stride
// multipliers. After reset and after every register write the input is held
// off while the plane layout check recomputes strides, plane bases and ends.
module i420_rect_outline_writer_core import irow_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data,
    // requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [12:0] i_rect_left,
    input  logic [12:0] i_rect_top,
    input  logic [11:0] i_rect_width,
    input  logic [11:0] i_rect_height,
    input  logic [11:0] i_border_thickness,
    input  logic [7:0]  i_color_luma,
    input  logic [7:0]  i_color_u,
    input  logic [7:0]  i_color_v,
    // pixel writes
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_write_enable,
    output logic [23:0] o_luma_address,
    output logic [23:0] o_u_address,
    output logic [23:0] o_v_address,
    output logic [7:0]  o_luma_value,
    output logic [7:0]  o_u_value,
    output logic [7:0]  o_v_value,
    output logic        o_last
);

    t_cfg    r_cfg;
    t_layout w_layout;
    logic    w_cfg_write;

    // walk state
    logic        r_busy;
    t_strip      r_strip;
    logic [11:0] r_row;
    logic [11:0] r_col;
    logic [12:0] r_left;
    logic [12:0] r_top;
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [11:0] r_thick;
    logic [23:0] r_color;

    logic        n_busy;
    t_strip      n_strip;
    logic [11:0] n_row;
    logic [11:0] n_col;

    logic        w_in_acc;
    logic        w_start;
    logic        w_emit;
    logic        w_s1_load;
    logic        w_out_load;

    logic signed [14:0] w_x;
    logic signed [14:0] w_y;
    logic [11:0] w_cols;
    logic [11:0] w_rows;
    logic [12:0] w_col_inc;
    logic [12:0] w_row_inc;
    logic        w_col_wrap;
    logic        w_row_wrap;
    logic        w_last;
    logic        w_pix_ok;
    logic [11:0] w_clamp;

    // pixel stage
    logic        r_s1_valid;
    logic        r_s1_en;
    logic        r_s1_last;
    logic [11:0] r_s1_x;
    logic [11:0] r_s1_y;
    logic [23:0] r_s1_color;

    // result stage
    logic        r_out_valid;
    logic        r_out_en;
    logic        r_out_last;
    logic [ADDR_BITS-1:0] r_out_luma_addr;
    logic [ADDR_BITS-1:0] r_out_u_addr;
    logic [ADDR_BITS-1:0] r_out_v_addr;
    logic [23:0] r_out_color;

    logic [25:0] w_luma_prod;
    logic [23:0] w_chroma_prod;
    logic [ADDR_BITS-1:0] w_luma_addr;
    logic [ADDR_BITS-1:0] w_u_addr;
    logic [ADDR_BITS-1:0] w_v_addr;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= 13'd640;
            r_cfg.frame_height  <= 13'd480;
            r_cfg.luma_stride   <= 14'd0;
            r_cfg.chroma_stride <= 13'd0;
            r_cfg.luma_offset   <= 24'd0;
            r_cfg.u_offset      <= 24'd0;
            r_cfg.v_offset      <= 24'd0;
            r_cfg.buffer_bytes  <= 25'd460800;
        end else if (w_cfg_write) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data[12:0];
                REG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data[12:0];
                REG_LUMA_STRIDE:   r_cfg.luma_stride   <= i_cfg_data[13:0];
                REG_CHROMA_STRIDE: r_cfg.chroma_stride <= i_cfg_data[12:0];
                REG_LUMA_OFFSET:   r_cfg.luma_offset   <= i_cfg_data[23:0];
                REG_U_OFFSET:      r_cfg.u_offset      <= i_cfg_data[23:0];
                REG_V_OFFSET:      r_cfg.v_offset      <= i_cfg_data[23:0];
                REG_BUFFER_BYTES:  r_cfg.buffer_bytes  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    irow_layout u_layout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (w_cfg_write),
        .i_cfg       (r_cfg),
        .o_layout    (w_layout)
    );

    // handshake and stage advance
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_in_ready = w_s1_load && w_layout.settled;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_start    = w_in_acc && (i_opcode == OP_START);
    assign w_emit     = w_in_acc && (i_opcode == OP_TICK) && r_busy;

    // pixel position and strip extent
    always_comb begin
        w_x    = 15'(signed'(r_left)) + $signed({3'b0, r_col});
        w_y    = 15'(signed'(r_top)) + $signed({3'b0, r_row});
        w_cols = r_thick;
        w_rows = r_height;
        case (r_strip)
            STRIP_TOP: begin
                w_cols = r_width;
                w_rows = r_thick;
            end
            STRIP_BOTTOM: begin
                w_y    = 15'(signed'(r_top)) + $signed({3'b0, r_height})
                       - $signed({3'b0, r_thick}) + $signed({3'b0, r_row});
                w_cols = r_width;
                w_rows = r_thick;
            end
            STRIP_RIGHT: begin
                w_x    = 15'(signed'(r_left)) + $signed({3'b0, r_width})
                       - $signed({3'b0, r_thick}) + $signed({3'b0, r_col});
            end
            default: begin
            end
        endcase
        w_pix_ok = !w_x[14] && !w_y[14]
                && (w_x[13:0] < {1'b0, r_cfg.frame_width})
                && (w_y[13:0] < {1'b0, r_cfg.frame_height});
    end

    // walk counters
    always_comb begin
        w_col_inc  = {1'b0, r_col} + 13'd1;
        w_row_inc  = {1'b0, r_row} + 13'd1;
        w_col_wrap = w_col_inc >= {1'b0, w_cols};
        w_row_wrap = w_row_inc >= {1'b0, w_rows};
        w_last     = w_col_wrap && w_row_wrap && (r_strip == STRIP_RIGHT);
        n_busy  = r_busy;
        n_strip = r_strip;
        n_row   = r_row;
        n_col   = w_col_inc[11:0];
        if (w_col_wrap) begin
            n_col = 12'd0;
            n_row = w_row_inc[11:0];
            if (w_row_wrap) begin
                n_row = 12'd0;
                case (r_strip)
                    STRIP_TOP:    n_strip = STRIP_BOTTOM;
                    STRIP_BOTTOM: n_strip = STRIP_LEFT;
                    STRIP_LEFT:   n_strip = STRIP_RIGHT;
                    default: begin
                        n_strip = STRIP_TOP;
                        n_busy  = 1'b0;
                    end
                endcase
            end
        end
    end

    // thickness clamped to width and height
    always_comb begin
        w_clamp = i_border_thickness;
        if (w_clamp > i_rect_width) begin
            w_clamp = i_rect_width;
        end
        if (w_clamp > i_rect_height) begin
            w_clamp = i_rect_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strip  <= STRIP_TOP;
            r_row    <= 12'd0;
            r_col    <= 12'd0;
            r_left   <= 13'd0;
            r_top    <= 13'd0;
            r_width  <= 12'd0;
            r_height <= 12'd0;
            r_thick  <= 12'd0;
            r_color  <= 24'd0;
        end else if (w_start) begin
            r_busy   <= (w_clamp != 12'd0);
            r_strip  <= STRIP_TOP;
            r_row    <= 12'd0;
            r_col    <= 12'd0;
            r_left   <= i_rect_left;
            r_top    <= i_rect_top;
            r_width  <= i_rect_width;
            r_height <= i_rect_height;
            r_thick  <= w_clamp;
            r_color  <= {i_color_luma, i_color_u, i_color_v};
        end else if (w_emit) begin
            r_busy  <= n_busy;
            r_strip <= n_strip;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // pixel stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && w_emit) begin
            r_s1_en    <= w_pix_ok && w_layout.ok;
            r_s1_last  <= w_last;
            r_s1_x     <= w_x[11:0];
            r_s1_y     <= w_y[11:0];
            r_s1_color <= r_color;
        end
    end

    // plane addresses
    always_comb begin
        w_luma_prod   = r_s1_y * w_layout.luma_stride;
        w_chroma_prod = r_s1_y[11:1] * w_layout.chroma_stride;
        w_luma_addr   = r_cfg.luma_offset + w_luma_prod[ADDR_BITS-1:0]
                      + ADDR_BITS'(r_s1_x);
        w_u_addr      = w_layout.u_base + w_chroma_prod[ADDR_BITS-1:0]
                      + ADDR_BITS'(r_s1_x[11:1]);
        w_v_addr      = w_layout.v_base + w_chroma_prod[ADDR_BITS-1:0]
                      + ADDR_BITS'(r_s1_x[11:1]);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out_en        <= r_s1_en;
            r_out_last      <= r_s1_last;
            r_out_luma_addr <= r_s1_en ? w_luma_addr : '0;
            r_out_u_addr    <= r_s1_en ? w_u_addr : '0;
            r_out_v_addr    <= r_s1_en ? w_v_addr : '0;
            r_out_color     <= r_s1_color;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_out_en;
    assign o_luma_address = r_out_luma_addr;
    assign o_u_address    = r_out_u_addr;
    assign o_v_address    = r_out_v_addr;
    assign o_luma_value   = r_out_color[23:16];
    assign o_u_value      = r_out_color[15:8];
    assign o_v_value      = r_out_color[7:0];
    assign o_last         = r_out_last;

endmodule
